// ----- rtl/core/bfk1_pkg.sv -----
package bfk1_pkg;

    localparam int TABLE_WORDS = 1042;
    localparam int ROUNDS      = 16;
    localparam int P_WORDS     = 18;
    localparam int S_WORDS     = 1024;
    localparam int IDX_W       = 11;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_KEY     = 2'd1,
        MODE_ENCRYPT = 2'd2,
        MODE_DECRYPT = 2'd3
    } mode_t;

    localparam logic CFG_GAME_CODE = 1'b0;
    localparam logic CFG_KEY_LEVEL = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COPY,
        ST_KPREP,
        ST_CIPH_RD,
        ST_CIPH_RUN,
        ST_CIPH_DONE,
        ST_XOR,
        ST_STORE,
        ST_DONE
    } state_t;

    // round unit states
    typedef enum logic [1:0] {
        RU_IDLE,
        RU_KEY,
        RU_SBOX,
        RU_FIN
    } ru_state_t;

    // cipher unit control
    typedef struct packed {
        logic        start;
        logic        decrypt;
        logic [31:0] left;
        logic [31:0] right;
    } ciph_req_t;

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

// ----- rtl/core/bfk1_round_unit.sv -----
// one feistel round per step: four s-box reads then combine
module bfk1_round_unit
    import bfk1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ciph_req_t   req,
    output logic        done,
    output logic [31:0] res_left,
    output logic [31:0] res_right,
    // round key read
    output logic [4:0]  p_addr,
    input  logic [31:0] p_data,
    // s-box reads: four banks
    output logic [7:0]  s_addr [4],
    input  logic [31:0] s_data [4]
);

    ru_state_t   state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        dec_reg, dec_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] c_reg, c_next;
    logic [31:0] f_val;
    logic [31:0] c_comb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RU_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dec_reg <= dec_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
    end

    assign f_val  = s_data[3] + (s_data[2] ^ (s_data[1] + s_data[0]));
    assign c_comb = p_data ^ a_reg;

    // p index: encrypt walks up from 0, decrypt walks down from 17
    always_comb
    begin
        if (state_reg == RU_FIN)
        begin
            p_addr = dec_reg ? (cnt_reg[0] ? 5'd1 : 5'd0) : (cnt_reg[0] ? 5'd17 : 5'd16);
        end
        else
        begin
            p_addr = dec_reg ? 5'(5'd17 - cnt_reg) : cnt_reg;
        end
    end

    // s-box addresses come from the key xor so the banks answer in the next cycle
    always_comb
    begin
        s_addr[0] = c_comb[31:24];
        s_addr[1] = c_comb[23:16];
        s_addr[2] = c_comb[15:8];
        s_addr[3] = c_comb[7:0];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dec_next   = dec_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        case (state_reg)
            RU_IDLE:
            begin
                if (req.start)
                begin
                    a_next     = req.left;
                    b_next     = req.right;
                    dec_next   = req.decrypt;
                    cnt_next   = '0;
                    state_next = RU_KEY;
                end
            end
            RU_KEY:
            begin
                c_next     = c_comb;
                state_next = RU_SBOX;
            end
            RU_SBOX:
            begin
                a_next = b_reg ^ f_val;
                b_next = c_reg;
                if (cnt_reg == 5'(ROUNDS - 1))
                begin
                    cnt_next   = '0;
                    state_next = RU_FIN;
                end
                else
                begin
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = RU_KEY;
                end
            end
            RU_FIN:
            begin
                // two whitening reads on one port
                if (cnt_reg[0] == 1'b0)
                begin
                    c_next   = p_data;
                    cnt_next = 5'd1;
                end
                else
                begin
                    state_next = RU_IDLE;
                end
            end
            default:
            begin
                state_next = RU_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done      = 1'b0;
        res_left  = b_reg;
        res_right = a_reg;
        if (state_reg == RU_FIN && cnt_reg[0] == 1'b1)
        begin
            done = 1'b1;
            if (dec_reg)
            begin
                res_left  = b_reg ^ c_reg;
                res_right = a_reg ^ p_data;
            end
            else
            begin
                res_right = a_reg ^ c_reg;
                res_left  = b_reg ^ p_data;
            end
        end
    end

endmodule

// ----- rtl/core/bfk1_sequencer.sv -----
// control of load, key schedule and cipher steps
module bfk1_sequencer
    import bfk1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  mode,
    input  logic [31:0] block_low,
    input  logic [31:0] block_high,
    input  logic [31:0] game_code_q,
    input  logic [1:0]  key_level_q,
    output logic        busy,
    output logic        strobe,
    output logic [31:0] out_low,
    output logic [31:0] out_high,
    output ciph_req_t   req,
    input  logic        ciph_done,
    input  logic [31:0] res_left,
    input  logic [31:0] res_right,
    // copy from initial table
    output logic [10:0] it_addr,
    input  logic [31:0] it_data,
    // working table access
    output logic        wt_we,
    output logic [10:0] wt_waddr,
    output logic [31:0] wt_wdata,
    output logic [4:0]  px_addr,
    input  logic [31:0] px_data
);

    state_t      state_reg, state_next;
    logic [10:0] cnt_reg, cnt_next;
    logic [1:0]  pass_reg, pass_next;
    logic [1:0]  phase_reg, phase_next;
    logic        keying_reg, keying_next;
    logic        dec_reg, dec_next;
    logic [31:0] k0_reg, k0_next;
    logic [31:0] k1_reg, k1_next;
    logic [31:0] k2_reg, k2_next;
    logic [31:0] l_reg, l_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] ol_reg, ol_next;
    logic [31:0] oh_reg, oh_next;
    logic        strobe_reg, strobe_next;
    logic        copy_v_reg, copy_v_next;
    logic [10:0] copy_a_reg, copy_a_next;
    logic        hi_reg, hi_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            copy_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            copy_v_reg <= copy_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        pass_reg   <= pass_next;
        phase_reg  <= phase_next;
        keying_reg <= keying_next;
        dec_reg    <= dec_next;
        k0_reg     <= k0_next;
        k1_reg     <= k1_next;
        k2_reg     <= k2_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        ol_reg     <= ol_next;
        oh_reg     <= oh_next;
        copy_a_reg <= copy_a_next;
        hi_reg     <= hi_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign strobe   = strobe_reg;
    assign out_low  = ol_reg;
    assign out_high = oh_reg;
    assign it_addr  = cnt_reg;
    assign px_addr  = cnt_reg[4:0];

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pass_next   = pass_reg;
        phase_next  = phase_reg;
        keying_next = keying_reg;
        dec_next    = dec_reg;
        k0_next     = k0_reg;
        k1_next     = k1_reg;
        k2_next     = k2_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        ol_next     = ol_reg;
        oh_next     = oh_reg;
        strobe_next = 1'b0;
        copy_v_next = 1'b0;
        copy_a_next = cnt_reg;
        hi_next     = hi_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ol_next = '0;
                    oh_next = '0;
                    case (mode)
                        MODE_LOAD:
                        begin
                            strobe_next = 1'b1;
                        end
                        MODE_KEY:
                        begin
                            cnt_next    = '0;
                            keying_next = 1'b1;
                            state_next  = ST_COPY;
                        end
                        default:
                        begin
                            keying_next = 1'b0;
                            dec_next    = (mode == MODE_DECRYPT);
                            l_next      = block_high;
                            r_next      = block_low;
                            state_next  = ST_CIPH_RD;
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                // read address cnt, write in the following cycle
                copy_v_next = 1'b1;
                if (cnt_reg == 11'(TABLE_WORDS - 1))
                begin
                    state_next = ST_KPREP;
                end
                else
                begin
                    cnt_next = cnt_reg + 11'd1;
                end
            end
            ST_KPREP:
            begin
                k0_next    = game_code_q;
                k1_next    = {1'b0, game_code_q[31:1]};
                k2_next    = {game_code_q[30:0], 1'b0};
                pass_next  = '0;
                phase_next = '0;
                dec_next   = 1'b0;
                l_next     = {game_code_q[30:0], 1'b0};
                r_next     = {1'b0, game_code_q[31:1]};
                state_next = ST_CIPH_RD;
            end
            ST_CIPH_RD:
            begin
                state_next = ST_CIPH_RUN;
            end
            ST_CIPH_RUN:
            begin
                if (ciph_done)
                begin
                    l_next     = res_left;
                    r_next     = res_right;
                    state_next = ST_CIPH_DONE;
                end
            end
            ST_CIPH_DONE:
            begin
                if (!keying_reg)
                begin
                    ol_next     = r_reg;
                    oh_next     = l_reg;
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    case (phase_reg)
                        2'd0:
                        begin
                            k2_next    = l_reg;
                            k1_next    = r_reg;
                            l_next     = r_reg;
                            r_next     = k0_reg;
                            phase_next = 2'd1;
                            state_next = ST_CIPH_RD;
                        end
                        2'd1:
                        begin
                            k1_next    = l_reg;
                            k0_next    = r_reg;
                            phase_next = 2'd2;
                            cnt_next   = '0;
                            state_next = ST_XOR;
                        end
                        default:
                        begin
                            cnt_next   = cnt_reg;
                            hi_next    = 1'b0;
                            state_next = ST_STORE;
                        end
                    endcase
                end
            end
            ST_XOR:
            begin
                // read-modify-write of round keys, one per cycle
                if (cnt_reg == 11'(P_WORDS - 1))
                begin
                    cnt_next   = '0;
                    l_next     = '0;
                    r_next     = '0;
                    phase_next = 2'd2;
                    state_next = ST_CIPH_RD;
                end
                else
                begin
                    cnt_next = cnt_reg + 11'd1;
                end
            end
            ST_STORE:
            begin
                if (hi_reg)
                begin
                    hi_next = 1'b0;
                    if (cnt_reg == 11'(P_WORDS + S_WORDS - 1))
                    begin
                        if ((pass_reg == 2'd1 && key_level_q != 2'd3) || pass_reg == 2'd2)
                        begin
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            pass_next  = pass_reg + 2'd1;
                            phase_next = '0;
                            if (pass_reg == 2'd1)
                            begin
                                k1_next = {k1_reg[30:0], 1'b0};
                                k2_next = {1'b0, k2_reg[31:1]};
                                l_next  = {1'b0, k2_reg[31:1]};
                                r_next  = {k1_reg[30:0], 1'b0};
                            end
                            else
                            begin
                                l_next = k2_reg;
                                r_next = k1_reg;
                            end
                            state_next = ST_CIPH_RD;
                        end
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 11'd1;
                        state_next = ST_CIPH_RD;
                    end
                end
                else
                begin
                    hi_next  = 1'b1;
                    cnt_next = cnt_reg + 11'd1;
                end
            end
            ST_DONE:
            begin
                keying_next = 1'b0;
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // working table write port
    always_comb
    begin
        wt_we    = 1'b0;
        wt_waddr = copy_a_reg;
        wt_wdata = it_data;
        if (copy_v_reg)
        begin
            wt_we = 1'b1;
        end
        else if (state_reg == ST_XOR)
        begin
            wt_we    = 1'b1;
            wt_waddr = cnt_reg;
            wt_wdata = px_data ^ (cnt_reg[0] ? bswap32(k1_reg) : bswap32(k0_reg));
        end
        else if (state_reg == ST_STORE)
        begin
            wt_we    = 1'b1;
            wt_waddr = cnt_reg;
            wt_wdata = hi_reg ? r_reg : l_reg;
        end
    end

    always_comb
    begin
        req.start   = (state_reg == ST_CIPH_RD);
        req.decrypt = dec_reg;
        req.left    = l_reg;
        req.right   = r_reg;
    end

endmodule

// ----- rtl/core/blowfish_key1_cipher.sv -----
// channel   | ports                                            | transfer when
// ----------+--------------------------------------------------+---------------------
// command   | mode table_index table_word block_low block_high | start && !busy
// result    | out_low out_high                                 | strobe (one cycle)
// config    | cfg_we cfg_index cfg_data                        | cfg_we
//
// load: result in the cycle after the transfer, the block never goes busy
// key: copy of the 1042-word initial table, then per pass 2 encryptions, 18 key xors and
//   521 chained encryptions; two passes, or three at key level 3
// encrypt/decrypt: each round is a key step then an s-box step
// rst_n clears control and the config registers only; tables hold garbage until loaded
// results are not stalled: each strobe is one cycle
module blowfish_key1_cipher
    import bfk1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [10:0] table_index,
    input  logic [31:0] table_word,
    input  logic [31:0] block_low,
    input  logic [31:0] block_high,
    output logic        strobe,
    output logic [31:0] out_low,
    output logic [31:0] out_high,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] game_code_reg;
    logic [1:0]  key_level_reg;

    // initial table memory
    logic [31:0] init_mem [TABLE_WORDS];
    logic [31:0] it_data;
    logic [10:0] it_addr;

    // working tables: round keys in flops, s-boxes in four banks
    logic [31:0] pkey_reg [P_WORDS];
    logic [31:0] sbox_mem0 [256];
    logic [31:0] sbox_mem1 [256];
    logic [31:0] sbox_mem2 [256];
    logic [31:0] sbox_mem3 [256];
    logic [31:0] s_data [4];
    logic [7:0]  s_addr [4];

    ciph_req_t   req;
    logic        ciph_done;
    logic [31:0] res_left, res_right;
    logic [4:0]  p_addr, px_addr;
    logic        wt_we;
    logic [10:0] wt_waddr;
    logic [31:0] wt_wdata;
    logic [10:0] s_waddr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            game_code_reg <= '0;
            key_level_reg <= 2'd2;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_GAME_CODE)
            begin
                game_code_reg <= cfg_data;
            end
            else
            begin
                key_level_reg <= cfg_data[1:0];
            end
        end
    end

    // load transfers write here; copy reads
    always_ff @(posedge clk)
    begin
        if (start && !busy && mode == MODE_LOAD && table_index < 11'(TABLE_WORDS))
        begin
            init_mem[table_index] <= table_word;
        end
        if (it_addr < 11'(TABLE_WORDS))
        begin
            it_data <= init_mem[it_addr];
        end
    end

    assign s_waddr = wt_waddr - 11'(P_WORDS);

    always_ff @(posedge clk)
    begin
        if (wt_we && wt_waddr < 11'(P_WORDS))
        begin
            pkey_reg[wt_waddr[4:0]] <= wt_wdata;
        end
        if (wt_we && wt_waddr >= 11'(P_WORDS))
        begin
            case (s_waddr[9:8])
                2'd0: sbox_mem0[s_waddr[7:0]] <= wt_wdata;
                2'd1: sbox_mem1[s_waddr[7:0]] <= wt_wdata;
                2'd2: sbox_mem2[s_waddr[7:0]] <= wt_wdata;
                default: sbox_mem3[s_waddr[7:0]] <= wt_wdata;
            endcase
        end
        s_data[0] <= sbox_mem0[s_addr[0]];
        s_data[1] <= sbox_mem1[s_addr[1]];
        s_data[2] <= sbox_mem2[s_addr[2]];
        s_data[3] <= sbox_mem3[s_addr[3]];
    end

    bfk1_round_unit u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .done      (ciph_done),
        .res_left  (res_left),
        .res_right (res_right),
        .p_addr    (p_addr),
        .p_data    (pkey_reg[p_addr < 5'(P_WORDS) ? p_addr : 5'd0]),
        .s_addr    (s_addr),
        .s_data    (s_data)
    );

    bfk1_sequencer u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .block_low   (block_low),
        .block_high  (block_high),
        .game_code_q (game_code_reg),
        .key_level_q (key_level_reg),
        .busy        (busy),
        .strobe      (strobe),
        .out_low     (out_low),
        .out_high    (out_high),
        .req         (req),
        .ciph_done   (ciph_done),
        .res_left    (res_left),
        .res_right   (res_right),
        .it_addr     (it_addr),
        .it_data     (it_data),
        .wt_we       (wt_we),
        .wt_waddr    (wt_waddr),
        .wt_wdata    (wt_wdata),
        .px_addr     (px_addr),
        .px_data     (pkey_reg[px_addr < 5'(P_WORDS) ? px_addr : 5'd0])
    );

    // a result only follows a busy cycle or a start
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy) || $past(start))
        else $error("result without command");

    // an accepted command makes the block busy unless it is a load
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode != MODE_LOAD) |=> busy)
        else $error("command not taken");

    // a load answers in the next cycle
    a_load_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_LOAD) |=> strobe)
        else $error("load without result");

endmodule
